@@ rtl/tmrr_pkg.sv @@
// ----------------------------------------------------------------------------
// Timer rate ratio reduction: shared package
// Field widths, packing constants and the request and response types of the
// shared divider.
// ----------------------------------------------------------------------------
`default_nettype none

package tmrr_pkg;

  // Field widths of the items.
  localparam int W_FREQ = 32;
  localparam int W_DIV  = 32;
  localparam int W_PRE  = 12;
  localparam int W_STEP = 8;
  localparam int W_CFG  = 24;

  // Packing of the timer configuration word.
  localparam int PRESCALE_BITS = 12;
  localparam int STEP_BITS     = 8;
  localparam int STEP_SHIFT    = 16;

  localparam logic [63:0] PRE_MASK  = (PRESCALE_BITS >= 64) ? '1 :
                                      ((64'd1 << PRESCALE_BITS) - 64'd1);
  localparam logic [63:0] STEP_MASK = (STEP_BITS >= 64) ? '1 :
                                      ((64'd1 << STEP_BITS) - 64'd1);

  // Step counter of the bit-serial divider.
  localparam int DIV_CNT_W = $clog2(W_FREQ);

  typedef struct packed {
    logic              start;
    logic [W_FREQ-1:0] dividend;
    logic [W_FREQ-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [W_FREQ-1:0] quot;
    logic [W_FREQ-1:0] rem;
  } div_rsp_t;

endpackage

`default_nettype wire

@@ rtl/tmrr_in_if.sv @@
// ----------------------------------------------------------------------------
// Timer rate ratio reduction: input channel
// Valid/ready channel that carries the two frequencies of one item.
// ----------------------------------------------------------------------------
`default_nettype none

interface tmrr_in_if;
  import tmrr_pkg::*;

  logic              valid;
  logic              ready;
  logic [W_FREQ-1:0] clk_hz;
  logic [W_FREQ-1:0] tick_hz;

  modport source (output valid, output clk_hz, output tick_hz, input ready);
  modport sink   (input valid, input clk_hz, input tick_hz, output ready);
endinterface

`default_nettype wire

@@ rtl/tmrr_out_if.sv @@
// ----------------------------------------------------------------------------
// Timer rate ratio reduction: result channel
// Valid/ready channel that carries the reduced ratio and the packed word.
// ----------------------------------------------------------------------------
`default_nettype none

interface tmrr_out_if;
  import tmrr_pkg::*;

  logic              valid;
  logic              ready;
  logic [W_DIV-1:0]  common_divisor;
  logic [W_PRE-1:0]  prescale_value;
  logic [W_STEP-1:0] step_value;
  logic [W_CFG-1:0]  cfg_word;

  modport source (output valid, output common_divisor, output prescale_value,
                  output step_value, output cfg_word, input ready);
  modport sink   (input valid, input common_divisor, input prescale_value,
                  input step_value, input cfg_word, output ready);
endinterface

`default_nettype wire

@@ rtl/tmrr_div.sv @@
// ----------------------------------------------------------------------------
// Timer rate ratio reduction: bit-serial divider
// Restoring unsigned divider, one quotient bit per cycle. Gives quotient and
// remainder with a one-cycle done pulse. The divisor must be nonzero.
// ----------------------------------------------------------------------------
`default_nettype none

module tmrr_div (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  tmrr_pkg::div_req_t  req,
  output tmrr_pkg::div_rsp_t  rsp
);
  import tmrr_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [W_FREQ-1:0]    quot_r;
  logic [W_FREQ-1:0]    rem_r;
  logic [W_FREQ-1:0]    dsor_r;

  logic [W_FREQ:0]      trial;
  logic [W_FREQ:0]      diff;
  logic                 fits;
  logic [W_FREQ-1:0]    quot_nxt;
  logic [W_FREQ-1:0]    rem_nxt;

  // Shift the next dividend bit into the partial remainder and try to
  // subtract the divisor.
  always_comb begin
    trial    = {rem_r, quot_r[W_FREQ-1]};
    diff     = trial - {1'b0, dsor_r};
    fits     = (trial >= {1'b0, dsor_r});
    rem_nxt  = fits ? diff[W_FREQ-1:0] : trial[W_FREQ-1:0];
    quot_nxt = {quot_r[W_FREQ-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !busy_r) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == DIV_CNT_W'(W_FREQ - 1))) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start && !busy_r) begin
      cnt_r  <= '0;
      quot_r <= req.dividend;
      rem_r  <= '0;
      dsor_r <= req.divisor;
    end else if (busy_r) begin
      cnt_r  <= cnt_r + DIV_CNT_W'(1);
      quot_r <= quot_nxt;
      rem_r  <= rem_nxt;
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quot = quot_r;
  assign rsp.rem  = rem_r;

endmodule

`default_nettype wire

@@ rtl/timer_rate_ratio_reduce_core.sv @@
// ----------------------------------------------------------------------------
// Timer rate ratio reduction: top level
// Reduces clk_hz : tick_hz by their greatest common divisor and packs
// the prescale and step values into the timer configuration word.
// ----------------------------------------------------------------------------
// One item at a time. All arithmetic runs on a single bit-serial divider:
// first the Euclidean remainder steps, then clk_hz / gcd and tick_hz / gcd.
// An item needs at most 46 remainder steps for 32-bit inputs.
// When either frequency is zero the gcd is the other one; when both are zero
// no division runs: the gcd state goes to the result state. The block is not
// ready while an item is in work or its result is still waiting to be taken.
`default_nettype none

module timer_rate_ratio_reduce_core (
  input  wire logic  clk,
  input  wire logic  rst_n,
  tmrr_in_if.sink    in_ch,
  tmrr_out_if.source out_ch
);
  import tmrr_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_GCD      = 6'b000010,
    S_GCD_WAIT = 6'b000100,
    S_DIVC     = 6'b001000,
    S_DIVS     = 6'b010000,
    S_OUT      = 6'b100000
  } state_t;

  state_t            state_r;
  state_t            state_nxt;
  logic [W_FREQ-1:0] clk_freq_r;
  logic [W_FREQ-1:0] cnt_freq_r;
  logic [W_FREQ-1:0] x_r;
  logic [W_FREQ-1:0] y_r;
  logic [W_FREQ-1:0] qc_r;
  logic [W_FREQ-1:0] qs_r;

  div_req_t          div_req;
  div_rsp_t          div_rsp;

  logic              in_fire;
  logic              out_fire;
  logic [W_FREQ-1:0] qc_m1;
  logic [63:0]       pre_m;
  logic [63:0]       stp_m;
  logic [63:0]       word;

  tmrr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;

  // Divider requests. Once the remainder is zero, x_r holds the gcd and the
  // same unit produces the two quotients.
  always_comb begin
    div_req = '0;
    unique case (state_r)
      S_GCD: begin
        div_req.start    = (y_r != '0) || (x_r != '0);
        div_req.dividend = (y_r != '0) ? x_r : clk_freq_r;
        div_req.divisor  = (y_r != '0) ? y_r : x_r;
      end
      S_DIVC: begin
        div_req.start    = div_rsp.done;
        div_req.dividend = cnt_freq_r;
        div_req.divisor  = x_r;
      end
      S_IDLE, S_GCD_WAIT, S_DIVS, S_OUT: begin
        div_req = '0;
      end
      default: begin
        div_req = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:     if (in_fire) state_nxt = S_GCD;
      S_GCD: begin
        if (y_r != '0) begin
          state_nxt = S_GCD_WAIT;
        end else if (x_r != '0) begin
          state_nxt = S_DIVC;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_GCD_WAIT: if (div_rsp.done) state_nxt = S_GCD;
      S_DIVC:     if (div_rsp.done) state_nxt = S_DIVS;
      S_DIVS:     if (div_rsp.done) state_nxt = S_OUT;
      S_OUT:      if (out_fire) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      clk_freq_r <= in_ch.clk_hz;
      cnt_freq_r <= in_ch.tick_hz;
      x_r        <= in_ch.clk_hz;
      y_r        <= in_ch.tick_hz;
    end
    if ((state_r == S_GCD) && (y_r == '0)) begin
      // Both quotients are zero when both frequencies are zero.
      qc_r <= '0;
      qs_r <= '0;
    end
    if ((state_r == S_GCD_WAIT) && div_rsp.done) begin
      x_r <= y_r;
      y_r <= div_rsp.rem;
    end
    if ((state_r == S_DIVC) && div_rsp.done) begin
      qc_r <= div_rsp.quot;
    end
    if ((state_r == S_DIVS) && div_rsp.done) begin
      qs_r <= div_rsp.quot;
    end
  end

  // A zero clock quotient wraps to all ones before masking.
  always_comb begin
    qc_m1 = qc_r - W_FREQ'(1);
    pre_m = {32'd0, qc_m1} & PRE_MASK;
    stp_m = {32'd0, qs_r} & STEP_MASK;
    word  = pre_m | (stp_m << STEP_SHIFT);
  end

  assign in_ch.ready           = (state_r == S_IDLE);
  assign out_ch.valid          = (state_r == S_OUT);
  assign out_ch.common_divisor = x_r;
  assign out_ch.prescale_value = pre_m[W_PRE-1:0];
  assign out_ch.step_value     = stp_m[W_STEP-1:0];
  assign out_ch.cfg_word       = word[W_CFG-1:0];

  a_ready_xor_result: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid))
    else $error("input ready while a result is pending");

  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_accept_starts_gcd: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == S_GCD))
    else $error("accepted item did not start the gcd loop");

  a_result_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire |=> in_ch.ready)
    else $error("block not ready after result was taken");

  a_no_div_by_zero: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> (div_req.divisor != '0))
    else $error("divider started with a zero divisor");

endmodule

`default_nettype wire
